### hw/rtl/luf_pkg.sv
// ----------------------------------------------------------------------------
// luf_pkg: shared types and constants
// Field widths, register indexes, the item record passed from the front end
// to the back end, and the saturation helper.
// ----------------------------------------------------------------------------
package luf_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 21;
    localparam int IDX_W   = 17;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 21;

    localparam logic [CFG_AW-1:0] REG_STRIDE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GHOST  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_COUNT  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_COEFF  = 2'd3;

    // One classified cell, ready for the datapath.
    typedef struct packed {
        logic signed [VALUE_W-1:0] vp;
        logic signed [VALUE_W-1:0] acc;
        logic                      last;
        logic                      emit;
        logic                      win;
        logic [IDX_W-1:0]          ps;
        logic [IDX_W-1:0]          back1;
        logic [IDX_W-1:0]          back2;
        logic [IDX_W-1:0]          pa;
        logic [IDX_W-1:0]          aback;
    } luf_item_t;

    // Clamp to the signed value range.
    function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            sat_val = hi[VALUE_W-1:0];
        end else if (x < lo) begin
            sat_val = lo[VALUE_W-1:0];
        end else begin
            sat_val = x[VALUE_W-1:0];
        end
    endfunction

endpackage

### hw/rtl/luf_ram.sv
// ----------------------------------------------------------------------------
// luf_ram: generic single-port-write, single-port-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module luf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/luf_front.sv
// ----------------------------------------------------------------------------
// luf_front: input classification
// Tracks the cell position, decides the flux window and emit condition,
// and works out the delay line addresses for each accepted cell.
// ----------------------------------------------------------------------------
module luf_front #(
    parameter int MAX_STRIDE = 1024,
    parameter int MAX_CELLS  = 1048576
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic [luf_pkg::VALUE_W-1:0] cell_value,
    input  logic [luf_pkg::VALUE_W-1:0] accum_value,
    input  logic                      last_cell,
    input  logic [10:0]               stride,
    input  logic [3:0]                ghost_layers,
    input  logic [20:0]               cell_count,
    output luf_pkg::luf_item_t        item
);
    import luf_pkg::*;

    localparam logic [IDX_W:0] SD = (IDX_W + 1)'(2 * MAX_STRIDE);
    localparam logic [IDX_W:0] MS = (IDX_W + 1)'(MAX_STRIDE);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] ps_reg, ps_next;
    logic [IDX_W-1:0] pa_reg, pa_next;

    logic [IDX_W:0]   s;
    logic [IDX_W:0]   s2;
    logic [3:0]       g;
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [IDX_W:0]   ps_w, pa_w;
    logic [IDX_W:0]   b1, b2, ab;

    // Clamp the configuration to its working range.
    always_comb begin
        if (stride == 11'd0) begin
            s = (IDX_W + 1)'(1);
        end else if (32'(stride) > 32'(MAX_STRIDE)) begin
            s = MS;
        end else begin
            s = (IDX_W + 1)'(stride);
        end
        s2 = s << 1;
        g  = (ghost_layers < 4'd2) ? 4'd2 : ghost_layers;
        n  = (32'(cell_count) > 32'(MAX_CELLS)) ? POS_W'(MAX_CELLS) : cell_count;
        lo = POS_W'(32'(g) * 32'(s));
        hi = (n > lo) ? (n - lo) : '0;
    end

    // Delay line addresses, each wrapped with one correction.
    always_comb begin
        ps_w = {1'b0, ps_reg};
        pa_w = {1'b0, pa_reg};
        b1 = (ps_w >= s)  ? (ps_w - s)  : (ps_w + SD - s);
        b2 = (ps_w >= s2) ? (ps_w - s2) : (ps_w + SD - s2);
        ab = (pa_w >= s)  ? (pa_w - s)  : (pa_w + MS - s);
    end

    // Classified item for the queue.
    always_comb begin
        item.vp    = $signed(cell_value);
        item.acc   = $signed(accum_value);
        item.last  = last_cell;
        item.emit  = (32'(pos_reg) >= 32'(s));
        item.win   = (pos_reg >= lo) && (pos_reg < hi);
        item.ps    = ps_reg;
        item.back1 = b1[IDX_W-1:0];
        item.back2 = b2[IDX_W-1:0];
        item.pa    = pa_reg;
        item.aback = ab[IDX_W-1:0];
    end

    // Position counters restart on the last cell or when the position wraps.
    always_comb begin
        pos_next = pos_reg;
        ps_next  = ps_reg;
        pa_next  = pa_reg;
        if (accept) begin
            if (last_cell) begin
                pos_next = '0;
                ps_next  = '0;
                pa_next  = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (&pos_reg || ({1'b0, ps_reg} == SD - 1'b1)) begin
                    ps_next = '0;
                end else begin
                    ps_next = ps_reg + 1'b1;
                end
                if (&pos_reg || ({1'b0, pa_reg} == MS - 1'b1)) begin
                    pa_next = '0;
                end else begin
                    pa_next = pa_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ps_reg  <= '0;
            pa_reg  <= '0;
        end else begin
            pos_reg <= pos_next;
            ps_reg  <= ps_next;
            pa_reg  <= pa_next;
        end
    end
endmodule

### hw/rtl/luf_queue.sv
// ----------------------------------------------------------------------------
// luf_queue: two-entry item queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module luf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  luf_pkg::luf_item_t push_item,
    input  logic               pop,
    output luf_pkg::luf_item_t head,
    output logic               full,
    output logic               empty
);
    import luf_pkg::*;

    luf_item_t   slot_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign head  = slot_reg[rd_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

    // Pointer and count update.
    always_comb begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_item;
        end
    end
endmodule

### hw/rtl/luf_back.sv
// ----------------------------------------------------------------------------
// luf_back: flux datapath and delay lines
// Reads the stencil neighbors, computes the limited flux with an iterative
// divider, updates the delay lines and produces the finished accumulator.
// ----------------------------------------------------------------------------
module luf_back #(
    parameter int MAX_STRIDE = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  luf_pkg::luf_item_t          head,
    input  logic                        empty,
    output logic                        pop,
    input  logic signed [18:0]          flux_coeff,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [luf_pkg::VALUE_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import luf_pkg::*;

    localparam int SDEPTH = 2 * MAX_STRIDE;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int AAW    = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1  = 4'd1;
    localparam logic [3:0] S_RD2  = 4'd2;
    localparam logic [3:0] S_RD3  = 4'd3;
    localparam logic [3:0] S_NORM = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_CORR = 4'd8;
    localparam logic [3:0] S_CF   = 4'd9;
    localparam logic [3:0] S_FLUX = 4'd10;
    localparam logic [3:0] S_SAT  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam logic [32:0] NORM_LIM = 33'h0_0040_0000;

    logic [3:0] state_reg, state_next;

    luf_item_t                 it_reg;
    logic signed [VALUE_W-1:0] vc_reg, vn_reg;
    logic signed [VALUE_W-1:0] acc_old_reg, flux_old_reg;
    logic [32:0]               m1_reg, m2_reg;
    logic                      neg1_reg, neg2_reg;
    logic signed [46:0]        nm_reg;
    logic signed [45:0]        aa_reg, bb_reg;
    logic [63:0]               rem_reg, dsh_reg;
    logic [16:0]               q_reg;
    logic [4:0]                qcnt_reg;
    logic                      qneg_reg;
    logic signed [18:0]        phi_reg;
    logic signed [51:0]        prod1_reg;
    logic signed [34:0]        sum_reg;
    logic signed [53:0]        prod2_reg;
    logic signed [VALUE_W-1:0] flux_reg;
    logic signed [VALUE_W-1:0] res_reg;
    logic                      res_last_reg;
    logic                      out_vld_reg;
    logic [VALUE_W-1:0]        out_data_reg;
    logic                      out_last_reg;

    logic [VALUE_W-1:0]   src_q;
    logic [2*VALUE_W-1:0] acc_q;
    logic [SAW-1:0]       src_raddr;
    logic                 ram_we;

    logic signed [32:0] d1, d2, diff;
    logic signed [32:0] d1_rd3, d2_rd3;
    logic signed [22:0] a, b;
    logic signed [23:0] sab;
    logic [45:0]        num_mag;
    logic [46:0]        den;
    logic signed [33:0] corr;
    logic signed [37:0] fl;
    logic signed [VALUE_W-1:0] t1;
    logic signed [VALUE_W-1:0] fin;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign ram_we   = (state_reg == S_FIN);
    assign src_raddr = (state_reg == S_RD1) ? it_reg.back1[SAW-1:0] : it_reg.back2[SAW-1:0];

    luf_ram #(.WIDTH(VALUE_W), .DEPTH(SDEPTH)) u_src (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (it_reg.ps[SAW-1:0]),
        .wdata (it_reg.vp),
        .raddr (src_raddr),
        .rdata (src_q)
    );

    luf_ram #(.WIDTH(2 * VALUE_W), .DEPTH(MAX_STRIDE)) u_acc (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (it_reg.pa[AAW-1:0]),
        .wdata ({flux_reg, it_reg.acc}),
        .raddr (it_reg.aback[AAW-1:0]),
        .rdata (acc_q)
    );

    // Differences formed from the neighbor read that lands in S_RD3.
    always_comb begin
        d1_rd3 = 33'(vc_reg) - 33'($signed(src_q));
        d2_rd3 = 33'(it_reg.vp) - 33'(vc_reg);
    end

    // Datapath terms used by the sequencer.
    always_comb begin
        d1      = 33'(vc_reg) - 33'(vn_reg);
        d2      = 33'(it_reg.vp) - 33'(vc_reg);
        diff    = 33'(it_reg.vp) - 33'(vn_reg);
        a       = neg1_reg ? -$signed({1'b0, m1_reg[21:0]}) : $signed({1'b0, m1_reg[21:0]});
        b       = neg2_reg ? -$signed({1'b0, m2_reg[21:0]}) : $signed({1'b0, m2_reg[21:0]});
        sab     = 24'(a) + 24'(b);
        den     = 47'($unsigned(aa_reg)) + 47'($unsigned(bb_reg));
        num_mag = nm_reg[46] ? 46'(-nm_reg) : nm_reg[45:0];
        corr    = 34'(prod1_reg >>> 18);
        fl      = 38'(prod2_reg >>> 16);
        t1      = sat_val(64'(33'(acc_old_reg) + 33'(flux_old_reg)));
        fin     = sat_val(64'(33'(t1) - 33'(flux_reg)));
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (!empty) state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_NORM;
            S_NORM: begin
                if (!it_reg.win) begin
                    state_next = S_FIN;
                end else if (d2 == 33'sd0) begin
                    state_next = S_CORR;
                end else if (m1_reg < NORM_LIM && m2_reg < NORM_LIM) begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = (den == '0) ? S_CORR : S_DIV;
            S_DIV:  if (qcnt_reg == 5'd0) state_next = S_CORR;
            S_CORR: state_next = S_CF;
            S_CF:   state_next = S_FLUX;
            S_FLUX: state_next = S_SAT;
            S_SAT:  state_next = S_FIN;
            S_FIN:  state_next = it_reg.emit ? S_OUT : S_IDLE;
            S_OUT:  if (!out_vld_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_vld_reg || m_tready)) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: it_reg <= head;
            S_RD2: begin
                vc_reg       <= $signed(src_q);
                acc_old_reg  <= $signed(acc_q[VALUE_W-1:0]);
                flux_old_reg <= $signed(acc_q[2*VALUE_W-1:VALUE_W]);
            end
            S_RD3: begin
                vn_reg <= $signed(src_q);
            end
            S_NORM: begin
                if (!it_reg.win) begin
                    flux_reg <= '0;
                end else if (d2 == 33'sd0) begin
                    phi_reg <= 19'sd65536;
                end
            end
            S_MUL1: begin
                nm_reg <= 47'(a * sab);
                aa_reg <= 46'(a * a);
                bb_reg <= 46'(b * b);
            end
            S_MUL2: begin
                rem_reg  <= {2'b0, num_mag, 16'b0};
                dsh_reg  <= {den, 17'b0};
                q_reg    <= '0;
                qcnt_reg <= 5'd17;
                qneg_reg <= nm_reg[46];
                if (den == '0) phi_reg <= 19'sd65536;
            end
            S_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[15:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[15:0], 1'b0};
                end
                dsh_reg  <= dsh_reg >> 1;
                qcnt_reg <= qcnt_reg - 1'b1;
                if (qcnt_reg == 5'd0) begin
                    if (rem_reg >= dsh_reg) begin
                        phi_reg <= qneg_reg ? -$signed({1'b0, q_reg, 1'b1})
                                            : $signed({1'b0, q_reg, 1'b1});
                    end else begin
                        phi_reg <= qneg_reg ? -$signed({1'b0, q_reg, 1'b0})
                                            : $signed({1'b0, q_reg, 1'b0});
                    end
                end
            end
            S_CORR: prod1_reg <= 52'(phi_reg * diff);
            S_CF:   sum_reg   <= 35'(vc_reg) + 35'(corr);
            S_FLUX: prod2_reg <= 54'(flux_coeff * sum_reg);
            S_SAT:  flux_reg  <= sat_val(64'(fl));
            S_FIN: begin
                res_reg      <= fin;
                res_last_reg <= it_reg.last;
            end
            S_OUT: begin
                if (!out_vld_reg || m_tready) begin
                    out_data_reg <= res_reg;
                    out_last_reg <= res_last_reg;
                end
            end
            default: ;
        endcase
        // Operand magnitudes: loaded after the reads, halved while too wide.
        if (state_reg == S_NORM && it_reg.win && d2 != 33'sd0 &&
            (m1_reg >= NORM_LIM || m2_reg >= NORM_LIM)) begin
            m1_reg <= m1_reg >> 1;
            m2_reg <= m2_reg >> 1;
        end
        if (state_reg == S_RD3) begin
            m1_reg   <= (d1_rd3[32]) ? 33'(-d1_rd3) : d1_rd3;
            m2_reg   <= (d2_rd3[32]) ? 33'(-d2_rd3) : d2_rd3;
            neg1_reg <= d1_rd3[32];
            neg2_reg <= d2_rd3[32];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule

### hw/rtl/limited_upwind_flux_stencil_core.sv
// ----------------------------------------------------------------------------
// limited_upwind_flux_stencil_core: van Albada limited upwind flux stencil
// Streams grid cells, applies the limited flux between neighbors and returns
// the finished accumulator of the cell one stride back.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions on s_* carry one cell each (source and accumulator
//   values); s_tlast marks the final cell of a block. Each input at position
//   p >= stride produces one output transaction on m_* with the finished
//   accumulator of cell p-stride; m_tlast follows the input's s_tlast.
//   Registers are written through cfg_we/cfg_addr/cfg_wdata while idle; the
//   user must keep to this, as the block does not enforce it. The datapath
//   works on one cell at a time. A cell outside the flux window goes through
//   the neighbor reads and the delay line update; a cell whose upwind
//   difference is zero also forms the correction and the flux; any other
//   cell in the window adds the normalizing shifts, the multiplies and the
//   18-step iterative divider. A cell that returns a result then passes
//   through the output register. A cell taken while busy waits in the queue.
//   Reset clears the position counters, queue and output valid and loads
//   the register defaults; the delay lines hold no reset value.
//   When m_tready is low, the finished result waits in the output register;
//   the queue still takes up to two further cells before s_tready drops.
// ----------------------------------------------------------------------------
module limited_upwind_flux_stencil_core #(
    parameter int MAX_STRIDE = 1024,
    parameter int MAX_CELLS  = 1048576
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // cell_value, accum_value
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [luf_pkg::VALUE_W-1:0]     m_tdata,   // updated_value
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [luf_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [luf_pkg::CFG_DW-1:0]      cfg_wdata
);
    import luf_pkg::*;

    logic [10:0]        stride_reg;
    logic [3:0]         ghost_reg;
    logic [20:0]        count_reg;
    logic signed [18:0] coeff_reg;

    luf_item_t f_item, q_head;
    logic      q_full, q_empty, q_pop, accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= 11'd1;
            ghost_reg  <= 4'd2;
            count_reg  <= 21'd1024;
            coeff_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STRIDE: stride_reg <= cfg_wdata[10:0];
                REG_GHOST:  ghost_reg  <= cfg_wdata[3:0];
                REG_COUNT:  count_reg  <= cfg_wdata[20:0];
                REG_COEFF:  coeff_reg  <= $signed(cfg_wdata[18:0]);
                default: ;
            endcase
        end
    end

    luf_front #(.MAX_STRIDE(MAX_STRIDE), .MAX_CELLS(MAX_CELLS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .cell_value   (s_tdata[31:0]),
        .accum_value  (s_tdata[63:32]),
        .last_cell    (s_tlast),
        .stride       (stride_reg),
        .ghost_layers (ghost_reg),
        .cell_count   (count_reg),
        .item         (f_item)
    );

    luf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (f_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    luf_back #(.MAX_STRIDE(MAX_STRIDE)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .empty      (q_empty),
        .pop        (q_pop),
        .flux_coeff (coeff_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );
endmodule

### tb/luf_checker.sv
// ----------------------------------------------------------------------------
// luf_checker: result checker for the limited upwind flux stencil core
// Watches the register port and both stream channels. Every accepted input
// transaction runs through an independent model of the flux stencil, and
// every accepted output transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module luf_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // cell_value, accum_value
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [luf_pkg::VALUE_W-1:0]   m_tdata,   // updated_value
    input  logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [luf_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [luf_pkg::CFG_DW-1:0]    cfg_wdata,
    output int                            fail_count,
    output int                            outstanding
);
    import luf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_STRIDE = 1024;
    localparam int  MAX_CELLS  = 1048576;
    localparam int  SRC_DEPTH  = 2 * MAX_STRIDE;
    localparam longint NORM_LIMIT = 64'sd1 << 22;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               block_end;
    } update_t;

    update_t pending_updates[$];

    longint source_line[SRC_DEPTH];
    longint accum_line[MAX_STRIDE];
    longint flux_line[MAX_STRIDE];
    logic [20:0] position;

    logic [10:0]        stride_r;
    logic [3:0]         ghost_r;
    logic [20:0]        count_r;
    logic signed [18:0] coeff_r;

    int errors = 0;

    assign fail_count  = errors;

    // Clamp to the signed 32-bit value range.
    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Van Albada limiter in Q16, with the operands normalized below 2^22.
    function automatic longint van_albada_phi(longint d1, longint d2);
        longint unsigned m1, m2, num_m, den, q;
        longint a, b, num;
        int k;
        if (d2 == 0) return 65536;
        m1 = (d1 < 0) ? longint'(-d1) : d1;
        m2 = (d2 < 0) ? longint'(-d2) : d2;
        k = 0;
        while ((m1 >> k) >= NORM_LIMIT || (m2 >> k) >= NORM_LIMIT) k++;
        a = longint'(m1 >> k);
        b = longint'(m2 >> k);
        if (d1 < 0) a = -a;
        if (d2 < 0) b = -b;
        num = a * (a + b);
        den = a * a + b * b;
        if (den == 0) return 65536;
        num_m = (num < 0) ? longint'(-num) : num;
        q = (num_m << 16) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Limited flux from the three stencil source values.
    function automatic longint limited_flux(longint vn, longint vc, longint vp);
        longint phi, corr, prod;
        phi  = van_albada_phi(vc - vn, vp - vc);
        corr = (phi * (vp - vn)) >>> 18;
        prod = longint'(coeff_r) * (vc + corr);
        return clamp32(prod >>> 16);
    endfunction

    // Advance the stencil by one cell and, from one stride in, queue the finished accumulator.
    function automatic void predict_cell(longint vp, longint acc, logic last);
        longint s, g, n, p, lo, hi, f;
        int ps, pa, back1, back2, aback;
        update_t u;
        s = (stride_r == 0) ? 1 : ((stride_r > MAX_STRIDE) ? MAX_STRIDE : stride_r);
        g = (ghost_r < 2) ? 2 : ghost_r;
        n = (count_r > MAX_CELLS) ? MAX_CELLS : count_r;
        p = position;
        lo = g * s;
        hi = (n > lo) ? n - lo : 0;
        ps = int'(p % SRC_DEPTH);
        pa = int'(p % MAX_STRIDE);
        back1 = int'((p + SRC_DEPTH - s) % SRC_DEPTH);
        back2 = int'((p + SRC_DEPTH - 2 * s) % SRC_DEPTH);
        aback = int'((p + MAX_STRIDE - s) % MAX_STRIDE);
        f = 0;
        if (p >= lo && p < hi) f = limited_flux(source_line[back2], source_line[back1], vp);
        if (p >= s) begin
            u.value = 32'(clamp32(clamp32(accum_line[aback] + flux_line[aback]) - f));
            u.block_end = last;
            pending_updates.push_back(u);
        end
        source_line[ps] = vp;
        accum_line[pa]  = acc;
        flux_line[pa]   = f;
        position = last ? 21'd0 : position + 21'd1;
    endfunction

    // Track registers, predict on input transactions, compare on output ones.
    always @(posedge aclk) begin
        update_t want;
        if (!aresetn) begin
            position = '0;
            stride_r = 11'd1;
            ghost_r  = 4'd2;
            count_r  = 21'd1024;
            coeff_r  = '0;
            pending_updates.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_STRIDE: stride_r = cfg_wdata[10:0];
                    REG_GHOST:  ghost_r  = cfg_wdata[3:0];
                    REG_COUNT:  count_r  = cfg_wdata[20:0];
                    REG_COEFF:  coeff_r  = cfg_wdata[18:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_cell(longint'($signed(s_tdata[31:0])),
                             longint'($signed(s_tdata[63:32])), s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (pending_updates.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: unexpected result %h last %b", m_tdata, m_tlast);
                end else begin
                    want = pending_updates.pop_front();
                    if (want.value !== m_tdata || want.block_end !== m_tlast) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h last %b, got %h last %b",
                                     want.value, want.block_end, m_tdata, m_tlast);
                    end
                end
            end
        end
        outstanding = pending_updates.size();
    end

endmodule

### tb/limited_upwind_flux_stencil_core_tb.sv
// ----------------------------------------------------------------------------
// limited_upwind_flux_stencil_core_tb: stimulus for the flux stencil core
// Runs directed blocks over value and register extremes, then random blocks
// under random stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module limited_upwind_flux_stencil_core_tb;
    import luf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_CELLS = 1650;
    localparam int STALL_LIMIT  = 20000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;   // cell_value, accum_value
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [VALUE_W-1:0]   m_tdata;        // updated_value
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int cells_sent = 0;
    int stall_cycles = 0;
    int hold_cycles = 0;
    bit gaps_on = 1'b1;

    limited_upwind_flux_stencil_core DUT (.*);

    luf_checker u_checker (.*);

    always #5 aclk = ~aclk;

    // Output side: long hold-offs on request, random stall bursts while gaps are on.
    initial begin
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL limited_upwind_flux_stencil_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_regs(int stride, int ghost, int cells, int coeff);
        cfg_we <= 1'b1;
        cfg_addr <= REG_STRIDE; cfg_wdata <= CFG_DW'(stride); @(posedge aclk);
        cfg_addr <= REG_GHOST;  cfg_wdata <= CFG_DW'(ghost);  @(posedge aclk);
        cfg_addr <= REG_COUNT;  cfg_wdata <= CFG_DW'(cells);  @(posedge aclk);
        cfg_addr <= REG_COEFF;  cfg_wdata <= CFG_DW'(coeff);  @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One input transaction, optionally after a random gap.
    task automatic send_cell(logic [31:0] value, logic [31:0] acc, logic last);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {acc, value};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        cells_sent++;
    endtask

    // Let every expected result drain, then allow for cells still in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Next source value in the style chosen for this block.
    function automatic logic [31:0] next_value(int style, logic [31:0] prev);
        case (style)
            0: return $urandom;
            1: return prev + 32'($signed($urandom_range(0, 8191)) - 4096);
            2: return ($urandom_range(0, 3) == 0) ? $urandom : prev;
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                                 : 32'h8000_0000 + $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_block(int length);
        int style;
        logic [31:0] value, acc;
        style = $urandom_range(0, 3);
        value = $urandom;
        for (int i = 0; i < length; i++) begin
            value = next_value(style, value);
            acc = ($urandom_range(0, 3) == 0) ? next_value(3, value) : $urandom;
            send_cell(value, acc, i == length - 1);
        end
    endtask

    initial begin
        logic [31:0] edge_vals[8] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0,
                                      32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 32'h1};
        int stride, ghost, cells, coeff, blocks;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extreme values through the flux window, with zero stride and ghost.
        write_regs(0, 0, 12, 131072);
        for (int i = 0; i < 12; i++)
            send_cell(edge_vals[i % 8], edge_vals[(i * 3) % 8], i == 11);
        drain();

        // Last cell before a full stride, then a short block at negative coefficient.
        write_regs(3, 2, 9, -131072);
        send_cell(32'h1234_5678, 32'h7fff_ffff, 1'b1);
        send_block(9);
        drain();

        // Empty flux window: accumulators pass through.
        write_regs(2, 8, 1, 65536);
        send_block(4);
        drain();

        // Oversized stride and cell count are clamped.
        write_regs(2047, 15, 2097151, 40000);
        send_block(1030);
        drain();

        // Random phases; one of them holds off the output for a long stretch.
        for (int phase = 0; cells_sent < TARGET_CELLS; phase++) begin
            stride = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            ghost  = $urandom_range(0, 15);
            case ($urandom_range(0, 5))
                0:       cells = $urandom_range(0, 4);
                1:       cells = 2097151;
                default: cells = $urandom_range(1, 60);
            endcase
            case ($urandom_range(0, 3))
                0:       coeff = $urandom_range(0, 1) ? 131072 : -131072;
                default: coeff = $urandom;
            endcase
            write_regs(stride, ghost, cells, coeff);
            if (phase == 2) hold_cycles = 300;
            if (cells_sent > TARGET_CELLS - 250) gaps_on = 1'b0;
            blocks = $urandom_range(1, 3);
            for (int b = 0; b < blocks; b++) send_block($urandom_range(1, 60));
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS limited_upwind_flux_stencil_core");
        end else begin
            $display("FAIL limited_upwind_flux_stencil_core");
        end
        $finish;
    end

endmodule

### limited_upwind_flux_stencil_core.f
hw/rtl/luf_pkg.sv
hw/rtl/luf_ram.sv
hw/rtl/luf_front.sv
hw/rtl/luf_queue.sv
hw/rtl/luf_back.sv
hw/rtl/limited_upwind_flux_stencil_core.sv
tb/luf_checker.sv
tb/limited_upwind_flux_stencil_core_tb.sv
